>>> hdl/sorted_priority_queue_top_defines.svh
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_defines
// Assertion macros for the sorted priority queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// assert that a implies b in the next cycle
`define SPQ_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("label failed");

// assert that a implies b in the same cycle
`define SPQ_ASSERT_NOW(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("label failed");

`endif

>>> hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;
    localparam int SPQ_DEPTH    = 16;
    localparam int SPQ_KEY_BITS = 10;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_POP,
        S_LIST,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic do_insert;
        logic do_pop;
        logic clr_idx;
        logic inc_idx;
        logic emit_entry;
        logic emit_none;
        logic emit_last;
        logic [1:0] emit_status;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_last;
    } sts_t;
endpackage
`default_nettype wire

>>> hdl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Priority queue of records kept in descending key order.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; opcode picks
// insert, pop or list, and the record fields matter for insert only.
// Each result shows on the result ports for one cycle with done high.
// Insert: one result after the S_INSERT and S_REPLY states (status ok or full).
// Pop: one result, registered from the S_POP state, carrying the head record.
// List: one result per stored record, one per cycle, registered from the S_LIST
// state; last marks the final one. Empty store gives status empty.
// Opcode 3 gives no result and leaves busy low.
// Sorted insertion compares every entry register with the new key at once
// and shifts the entries below the slot down in parallel.
// busy covers the whole request and drops in the cycle that shows the final
// result, so the next request can be taken at that edge. Reset empties the store.
// The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH    = SPQ_DEPTH,
    parameter int KEY_BITS = SPQ_KEY_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          opcode,
    input  wire logic [KEY_BITS-1:0] key,
    input  wire logic [63:0]         name_part_a,
    input  wire logic [63:0]         name_part_b,
    input  wire logic [31:0]         name_part_c,
    input  wire logic [33:0]         student_id,
    output logic                     done,
    output logic [1:0]               status,
    output logic [KEY_BITS-1:0]      out_key,
    output logic [63:0]              out_name_a,
    output logic [63:0]              out_name_b,
    output logic [31:0]              out_name_c,
    output logic [33:0]              out_id,
    output logic                     entry_valid,
    output logic                     last
);
    cmd_t cmd;
    sts_t sts;

    spq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    spq_datapath #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .key          (key),
        .name_part_a  (name_part_a),
        .name_part_b  (name_part_b),
        .name_part_c  (name_part_c),
        .student_id   (student_id),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .status       (status),
        .out_key      (out_key),
        .out_name_a   (out_name_a),
        .out_name_b   (out_name_b),
        .out_name_c   (out_name_c),
        .out_id       (out_id),
        .entry_valid  (entry_valid),
        .last         (last)
    );
endmodule
`default_nettype wire

>>> hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Command sequencer of the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] opcode,
    input  sts_t            sts,
    output logic            busy,
    output cmd_t            cmd
);
    state_t state_reg, state_next;
    logic [1:0] rsp_reg, rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        OP_INSERT: state_next = S_INSERT;
                        OP_POP:    state_next = S_POP;
                        OP_LIST:   state_next = S_LIST;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_INSERT:
            begin
                rsp_next   = sts.full ? ST_FULL : ST_OK;
                state_next = S_REPLY;
            end
            S_POP:  state_next = S_IDLE;
            S_LIST: if (sts.empty || sts.idx_last) state_next = S_IDLE;
            S_REPLY: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE: cmd.clr_idx = 1'b1;
            S_INSERT: cmd.do_insert = !sts.full;
            S_POP:
            begin
                cmd.emit_last = 1'b1;
                if (sts.empty)
                begin
                    cmd.emit_none   = 1'b1;
                    cmd.emit_status = ST_EMPTY;
                end
                else
                begin
                    cmd.emit_entry = 1'b1;
                    cmd.do_pop     = 1'b1;
                end
            end
            S_LIST:
            begin
                cmd.inc_idx = 1'b1;
                if (sts.empty)
                begin
                    cmd.emit_none   = 1'b1;
                    cmd.emit_status = ST_EMPTY;
                    cmd.emit_last   = 1'b1;
                end
                else
                begin
                    cmd.emit_entry = 1'b1;
                    cmd.emit_last  = sts.idx_last;
                end
            end
            S_REPLY:
            begin
                cmd.emit_none   = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = rsp_reg;
            end
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Entry registers with parallel compare-and-shift and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH    = SPQ_DEPTH,
    parameter int KEY_BITS = SPQ_KEY_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [KEY_BITS-1:0] key,
    input  wire logic [63:0]         name_part_a,
    input  wire logic [63:0]         name_part_b,
    input  wire logic [31:0]         name_part_c,
    input  wire logic [33:0]         student_id,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output logic                     done,
    output logic [1:0]               status,
    output logic [KEY_BITS-1:0]      out_key,
    output logic [63:0]              out_name_a,
    output logic [63:0]              out_name_b,
    output logic [31:0]              out_name_c,
    output logic [33:0]              out_id,
    output logic                     entry_valid,
    output logic                     last
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int RW = KEY_BITS + 64 + 64 + 32 + 34;

    logic [RW-1:0] ent_reg [DEPTH];
    logic [RW-1:0] in_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [DEPTH-1:0] ge;
    logic [RW-1:0] sel;

    assign sts.full     = (cnt_reg == CW'(DEPTH));
    assign sts.empty    = (cnt_reg == '0);
    assign sts.idx_last = (idx_reg + 1'b1 == cnt_reg);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i] = (CW'(i) < cnt_reg) &&
                    (ent_reg[i][RW-1 -: KEY_BITS] >= in_reg[RW-1 -: KEY_BITS]);
        end
    end

    assign sel = cmd.do_pop ? ent_reg[0] : ent_reg[idx_reg[IW-1:0]];

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_reg <= {key, name_part_a, name_part_b, name_part_c, student_id};
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cmd.do_insert)
            begin
                if (!ge[i])
                begin
                    if (i == 0 || ge[(i == 0) ? 0 : i - 1])
                        ent_reg[i] <= in_reg;
                    else
                        ent_reg[i] <= ent_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (cmd.do_pop && i < DEPTH - 1)
                ent_reg[i] <= ent_reg[(i < DEPTH - 1) ? i + 1 : i];
        end
        {out_key, out_name_a, out_name_b, out_name_c, out_id} <=
            cmd.emit_entry ? sel : '0;
        status <= cmd.emit_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            idx_reg     <= '0;
            done        <= 1'b0;
            entry_valid <= 1'b0;
            last        <= 1'b0;
        end
        else
        begin
            if (cmd.do_insert)
                cnt_reg <= cnt_reg + 1'b1;
            else if (cmd.do_pop)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.clr_idx)
                idx_reg <= '0;
            else if (cmd.inc_idx)
                idx_reg <= idx_reg + 1'b1;
            done        <= cmd.emit_entry || cmd.emit_none;
            entry_valid <= cmd.emit_entry;
            last        <= cmd.emit_last;
        end
    end
endmodule
`default_nettype wire

>>> hdl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_assertions
// Port-level checks of the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_top_defines.svh"
module spq_assertions
    import spq_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] opcode,
    input wire logic       done,
    input wire logic [1:0] status,
    input wire logic       entry_valid,
    input wire logic       last
);
    `SPQ_ASSERT_NEXT(a_start_busy, start && !busy && opcode != 2'd3, busy)
    `SPQ_ASSERT_NOW(a_valid_ok, done && entry_valid, status == ST_OK)
    `SPQ_ASSERT_NOW(a_done_busy, done && !last, busy)
    `SPQ_ASSERT_NOW(a_none_last, done && !entry_valid, last)
endmodule
`default_nettype wire

bind sorted_priority_queue_top spq_assertions u_spq_assertions (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .done        (done),
    .status      (status),
    .entry_valid (entry_valid),
    .last        (last)
);
